// ===== src/swm_pkg.sv =====
// Shared types and constants of the sliding window maximum block.
package swm_pkg;

	localparam int SAMPLE_W = 32;
	localparam int WS_W = 9;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_SIZE = 2'd0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HEAD,
		ST_HEAD_WAIT,
		ST_TAIL,
		ST_TAIL_WAIT,
		ST_PUSH,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load_in;
		logic drop_head;
		logic pop_tail;
		logic push;
		logic load_out;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic count_zero;
		logic head_old;
		logic tail_smaller;
		logic emit_due;
		logic last;
		logic out_free;
	} status_t;

endpackage

// ===== src/swm_ctrl.sv =====
// Controller state machine of the sliding window maximum block.
module swm_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  swm_pkg::status_t   sts,
	output swm_pkg::cmd_t      cmd
);

	swm_pkg::state_t state_q;
	swm_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= swm_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			swm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = swm_pkg::ST_HEAD;
				end
			end
			swm_pkg::ST_HEAD: begin
				if (!sts.count_zero && sts.head_old) begin
					cmd.drop_head = 1'b1;
					state_d = swm_pkg::ST_HEAD_WAIT;
				end else if (!sts.count_zero && sts.tail_smaller) begin
					cmd.pop_tail = 1'b1;
					state_d = swm_pkg::ST_TAIL_WAIT;
				end else begin
					state_d = swm_pkg::ST_PUSH;
				end
			end
			swm_pkg::ST_HEAD_WAIT: begin
				state_d = swm_pkg::ST_HEAD;
			end
			swm_pkg::ST_TAIL: begin
				if (!sts.count_zero && sts.tail_smaller) begin
					cmd.pop_tail = 1'b1;
					state_d = swm_pkg::ST_TAIL_WAIT;
				end else begin
					state_d = swm_pkg::ST_PUSH;
				end
			end
			swm_pkg::ST_TAIL_WAIT: begin
				state_d = swm_pkg::ST_TAIL;
			end
			swm_pkg::ST_PUSH: begin
				cmd.push = 1'b1;
				state_d = swm_pkg::ST_EMIT;
			end
			swm_pkg::ST_EMIT: begin
				if (!sts.emit_due || sts.out_free) begin
					cmd.load_out = sts.emit_due;
					cmd.clear = sts.last;
					state_d = swm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = swm_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== src/swm_datapath.sv =====
// Datapath of the sliding window maximum block: deque store, pointers and output register.
module swm_datapath #(
	parameter int WINDOW_MAX = 256
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  swm_pkg::cmd_t                     cmd,
	output swm_pkg::status_t                  sts,
	input  logic signed [swm_pkg::SAMPLE_W-1:0] sample,
	input  logic                              last_in_seq,
	input  logic [swm_pkg::WS_W-1:0]          window_size,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [swm_pkg::SAMPLE_W-1:0] window_max
);

	localparam int AW = $clog2(WINDOW_MAX);
	localparam int PW = $clog2(2 * WINDOW_MAX);
	localparam int CW = $clog2(WINDOW_MAX + 1);
	localparam int EW = (CW > swm_pkg::WS_W) ? CW : swm_pkg::WS_W;
	localparam int MW = (PW > EW) ? PW : EW;
	localparam int DW = swm_pkg::SAMPLE_W + PW;

	logic [DW-1:0] mem_q [WINDOW_MAX];
	logic [DW-1:0] head_rd_q;
	logic [DW-1:0] tail_rd_q;

	logic signed [swm_pkg::SAMPLE_W-1:0] sample_q;
	logic                                last_q;
	logic signed [swm_pkg::SAMPLE_W-1:0] emit_val_q;
	logic signed [swm_pkg::SAMPLE_W-1:0] window_max_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [CW-1:0] count_q;
	logic [PW-1:0] pos_q;
	logic [EW-1:0] fill_q;
	logic          emit_due_q;
	logic          out_valid_q;

	logic [EW-1:0] ws_ext;
	logic [EW-1:0] w_eff;
	logic [AW-1:0] head_next;
	logic [AW-1:0] tail_next;
	logic [AW-1:0] tail_prev;
	logic [PW:0]   age_raw;
	logic [PW-1:0] head_pos;
	logic [PW-1:0] pos_next;
	logic [EW-1:0] fill_next;
	logic signed [swm_pkg::SAMPLE_W-1:0] tail_val;
	logic signed [swm_pkg::SAMPLE_W-1:0] head_val;

	always_comb begin
		ws_ext = EW'(window_size);
		if (ws_ext == '0) begin
			w_eff = EW'(1);
		end else if (ws_ext > EW'(WINDOW_MAX)) begin
			w_eff = EW'(WINDOW_MAX);
		end else begin
			w_eff = ws_ext;
		end
		head_next = (head_q == AW'(WINDOW_MAX - 1)) ? '0 : head_q + AW'(1);
		tail_next = (tail_q == AW'(WINDOW_MAX - 1)) ? '0 : tail_q + AW'(1);
		tail_prev = (tail_q == '0) ? AW'(WINDOW_MAX - 1) : tail_q - AW'(1);
		head_pos = head_rd_q[PW-1:0];
		head_val = $signed(head_rd_q[DW-1 -: swm_pkg::SAMPLE_W]);
		tail_val = $signed(tail_rd_q[DW-1 -: swm_pkg::SAMPLE_W]);
		age_raw = {1'b0, pos_q} - {1'b0, head_pos};
		if (pos_q < head_pos) begin
			age_raw = age_raw + (PW + 1)'(2 * WINDOW_MAX);
		end
		if (({1'b0, pos_q} + (PW + 1)'(1)) >= (PW + 1)'(2 * WINDOW_MAX)) begin
			pos_next = '0;
		end else begin
			pos_next = pos_q + PW'(1);
		end
		fill_next = (fill_q < w_eff) ? fill_q + EW'(1) : fill_q;
	end

	assign sts.count_zero = (count_q == '0);
	assign sts.head_old = MW'(age_raw[PW-1:0]) >= MW'(w_eff);
	assign sts.tail_smaller = tail_val < sample_q;
	assign sts.emit_due = emit_due_q;
	assign sts.last = last_q;
	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem_q[tail_q] <= {sample_q, pos_q};
		end
		head_rd_q <= mem_q[head_q];
		tail_rd_q <= mem_q[tail_prev];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			sample_q <= sample;
			last_q <= last_in_seq;
		end
		if (cmd.push) begin
			emit_val_q <= (count_q == '0) ? sample_q : head_val;
		end
		if (cmd.load_out) begin
			window_max_q <= emit_val_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			pos_q <= '0;
			fill_q <= '0;
			emit_due_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			priority if (cmd.clear) begin
				head_q <= '0;
				tail_q <= '0;
				count_q <= '0;
				pos_q <= '0;
				fill_q <= '0;
			end else if (cmd.drop_head) begin
				head_q <= head_next;
				count_q <= count_q - CW'(1);
			end else if (cmd.pop_tail) begin
				tail_q <= tail_prev;
				count_q <= count_q - CW'(1);
			end else if (cmd.push) begin
				tail_q <= tail_next;
				count_q <= count_q + CW'(1);
				pos_q <= pos_next;
				fill_q <= fill_next;
				emit_due_q <= (fill_next >= w_eff);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign window_max = window_max_q;

endmodule

// ===== src/sliding_window_max.sv =====
// Top level of the sliding window maximum block.
// Samples arrive on the input request channel (in_valid, in_ready, sample,
// last_in_seq); window maxima leave on the output channel (out_valid,
// out_ready, window_max). The window length is written through the APB
// port and read back at address 0; the user must write it only while the
// block is idle, which the block itself does not enforce. Each sample
// passes the accept, head, push and emit steps, plus a drop and a wait step
// for every stale head entry and a pop and a wait step for every smaller
// tail entry; the wait steps allow for the registered reads of the deque
// store. A result is staged when the store is updated and moves to the
// output register once it is free. A sample marked last is processed as
// usual and then clears the deque and the sequence counters.
// Reset empties the deque, clears the counters and sets the window length
// to one. The store itself needs no clearing pass. While the receiver
// stalls, a finished result waits in the output register and the next
// sample is still accepted; only its own result waits for the register.
module sliding_window_max #(
	parameter int WINDOW_MAX = 256
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [swm_pkg::SAMPLE_W-1:0]   sample,
	input  logic                                  last_in_seq,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [swm_pkg::SAMPLE_W-1:0]   window_max,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [swm_pkg::CFG_ADDR_W-1:0]        paddr,
	input  logic [swm_pkg::CFG_DATA_W-1:0]        pwdata,
	output logic [swm_pkg::CFG_DATA_W-1:0]        prdata,
	output logic                                  pready
);

	logic [swm_pkg::WS_W-1:0] window_size_q;
	swm_pkg::cmd_t            cmd;
	swm_pkg::status_t         sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= swm_pkg::WS_W'(1);
		end else if (psel && penable && pwrite) begin
			window_size_q <= pwdata[swm_pkg::WS_W-1:0];
		end
	end

	assign pready = 1'b1;

	always_comb begin
		prdata = '0;
		if (paddr == swm_pkg::REG_WINDOW_SIZE) begin
			prdata = swm_pkg::CFG_DATA_W'(window_size_q);
		end
	end

	swm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	swm_datapath #(
		.WINDOW_MAX (WINDOW_MAX)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.sample      (sample),
		.last_in_seq (last_in_seq),
		.window_size (window_size_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.window_max  (window_max)
	);

endmodule
